/* rtl/bmst_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmst_pkg: shared types and constants of the barcode selection table
// Holds the table geometry, field widths and codes that the sequencer, the
// bar front end and the shared max-plus unit use, and that unit's saturating add.
// ---------------------------------------------------------------------------
package bmst_pkg;

    // Table geometry and value width.
    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLUMNS = 8;
    localparam int VALUE_BITS  = 32;

    // Field widths of the item channels.
    localparam int BAR_W   = 32;
    localparam int CELL_W  = 40;
    localparam int IDX_W   = 3;
    localparam int SCALE_W = 16;
    localparam int COUNT_W = 5;

    // Products and sums inside the bar front end.
    localparam int PROD_W  = SCALE_W + BAR_W;
    localparam int SHIFT_W = PROD_W - 8;
    localparam int SL_W    = BAR_W + 1;

    // Table store: one layer bit, then row and column.
    localparam int ADDR_W      = 1 + 2 * IDX_W;
    localparam int TABLE_DEPTH = 2 ** ADDR_W;

    // Highest usable row and column indices.
    localparam logic [IDX_W-1:0] ROW_TOP = IDX_W'(MAX_ROWS - 1);
    localparam logic [IDX_W-1:0] COL_TOP = IDX_W'(MAX_COLUMNS - 1);

    localparam logic [BAR_W-1:0]   VALUE_MASK = BAR_W'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [CELL_W-1:0]  CELL_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Configuration register indices.
    typedef enum logic [1:0] {
        CFG_ROW_LIMIT    = 2'd0,
        CFG_COLUMN_LIMIT = 2'd1,
        CFG_LENGTH_SCALE = 2'd2
    } cfg_index_e;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SCALE_W;

    // Item opcodes.
    localparam logic OP_BAR    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Requests from the sequencer to the table store.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              clear;
    } store_req_t;

    // Control of the shared max-plus unit.
    typedef struct packed {
        logic base_zero;
        logic enable;
    } alu_ctrl_t;

    // Addition that saturates at the largest cell value.
    function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] a,
                                                  input logic [CELL_W-1:0] b);
        logic [CELL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
    endfunction

endpackage

/* rtl/bmst_in_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmst_in_if: input item channel of the barcode selection table
// Carries one bar or a finish request per item under valid and ready.
// ---------------------------------------------------------------------------
interface bmst_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [bmst_pkg::BAR_W-1:0] birth;
    logic [bmst_pkg::BAR_W-1:0] death;

    modport source (output valid, output opcode, output birth, output death, input ready);
    modport sink   (input valid, input opcode, input birth, input death, output ready);
endinterface

/* rtl/bmst_out_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmst_out_if: result item channel of the barcode selection table
// Carries one table cell with its position per item under valid and ready.
// ---------------------------------------------------------------------------
interface bmst_out_if;
    logic                        valid;
    logic                        ready;
    logic [bmst_pkg::CELL_W-1:0] cell_value;
    logic [bmst_pkg::IDX_W-1:0]  row_index;
    logic [bmst_pkg::IDX_W-1:0]  column_index;
    logic                        last;

    modport source (output valid, output cell_value, output row_index,
                    output column_index, output last, input ready);
    modport sink   (input valid, input cell_value, input row_index,
                    input column_index, input last, output ready);
endinterface

/* rtl/bmst_cell_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmst_cell_store: two-layer score table memory
// One write port and one registered read port. A valid bit per entry makes
// untouched entries read as zero after reset or after a table clear.
// ---------------------------------------------------------------------------
module bmst_cell_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bmst_pkg::store_req_t        req,
    input  logic [bmst_pkg::CELL_W-1:0] wr_data,
    output logic [bmst_pkg::CELL_W-1:0] rd_data
);

    logic [bmst_pkg::CELL_W-1:0]      mem [bmst_pkg::TABLE_DEPTH];
    logic [bmst_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [bmst_pkg::CELL_W-1:0]      rd_data_reg;
    logic                             rd_hit_reg;

    // Memory array with its registered read.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Per-entry valid bits, cleared at once by reset or a table clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since the last clear reads as zero.
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

/* rtl/bmst_bar_prep.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmst_bar_prep: bar length and short-plus-length front end
// Loads a bar, then forms the scaled length in a product register, its
// minimum with the birth value, and the registered sum of that short value and length.
// ---------------------------------------------------------------------------
module bmst_bar_prep (
    input  logic                         clk,
    input  logic                         load,
    input  logic [bmst_pkg::BAR_W-1:0]   birth,
    input  logic [bmst_pkg::BAR_W-1:0]   death,
    input  logic [bmst_pkg::SCALE_W-1:0] scale,
    output logic [bmst_pkg::BAR_W-1:0]   bar_length,
    output logic [bmst_pkg::SL_W-1:0]    short_length
);

    logic [bmst_pkg::BAR_W-1:0]   birth_m;
    logic [bmst_pkg::BAR_W-1:0]   death_m;
    logic [bmst_pkg::BAR_W-1:0]   birth_reg;
    logic [bmst_pkg::BAR_W-1:0]   len_reg;
    logic [bmst_pkg::PROD_W-1:0]  prod_reg;
    logic [bmst_pkg::SL_W-1:0]    sl_reg;
    logic [bmst_pkg::SHIFT_W-1:0] scaled;
    logic [bmst_pkg::SHIFT_W-1:0] birth_wide;
    logic [bmst_pkg::SHIFT_W-1:0] short_val;

    assign birth_m = birth & bmst_pkg::VALUE_MASK;
    assign death_m = death & bmst_pkg::VALUE_MASK;

    // Scaled length is truncated by the eight fraction bits of the scale.
    assign scaled     = prod_reg[bmst_pkg::PROD_W-1:8];
    assign birth_wide = bmst_pkg::SHIFT_W'(birth_reg);
    assign short_val  = (scaled > birth_wide) ? birth_wide : scaled;

    // Length on load, then the product, then the short-plus-length sum.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            birth_reg <= birth_m;
            len_reg   <= (death_m > birth_m) ? (death_m - birth_m) : '0;
        end
        prod_reg <= bmst_pkg::PROD_W'(scale) * bmst_pkg::PROD_W'(len_reg);
        sl_reg   <= bmst_pkg::SL_W'(short_val[bmst_pkg::BAR_W-1:0])
                    + bmst_pkg::SL_W'(len_reg);
    end

    assign bar_length   = len_reg;
    assign short_length = sl_reg;

endmodule

/* rtl/bmst_max_plus.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmst_max_plus: shared max-plus unit
// Adds an addend to a table operand with saturation and keeps the larger of
// that sum and a running maximum or zero. Used once per phase of every cell update.
// ---------------------------------------------------------------------------
module bmst_max_plus (
    input  bmst_pkg::alu_ctrl_t         ctrl,
    input  logic [bmst_pkg::CELL_W-1:0] base,
    input  logic [bmst_pkg::CELL_W-1:0] operand,
    input  logic [bmst_pkg::CELL_W-1:0] addend,
    output logic [bmst_pkg::CELL_W-1:0] result
);

    logic [bmst_pkg::CELL_W-1:0] base_sel;
    logic [bmst_pkg::CELL_W-1:0] cand;

    // A disabled candidate counts as zero, which never wins over the base.
    assign base_sel = ctrl.base_zero ? '0 : base;
    assign cand     = ctrl.enable ? bmst_pkg::sat_add(operand, addend) : '0;
    assign result   = (cand > base_sel) ? cand : base_sel;

endmodule

/* rtl/barcode_max_selection_table_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// barcode_max_selection_table_core: max-plus selection table over bars
// A small sequencer walks the table cell by cell and drives one shared
// max-plus unit against a two-layer table memory.
// ---------------------------------------------------------------------------
//
//  Channel   | Dir | Handshake     | Item
//  ----------+-----+---------------+------------------------------------------
//  bar_in    | in  | valid / ready | opcode, birth, death
//  cell_out  | out | valid / ready | cell_value, row_index, column_index, last
//  cfg       | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
//  A bar item is accepted, passes the bar front end (S_MUL, S_SUM) and then
//  visits each cell with three reads of the single read port and one write.
//  A finish item runs a pass per padding bar up to L+P bars, then emits each
//  cell through S_ER and S_EL while the sink is ready.
//  Reset is asynchronous; per-entry valid bits make the table read as zero, so
//  no clearing pass follows. bar_in is ready only while the sequencer is idle.
// ---------------------------------------------------------------------------
module barcode_max_selection_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    bmst_in_if.sink                        bar_in,
    bmst_out_if.source                     cell_out,
    input  logic                           cfg_we,
    input  logic [bmst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmst_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_SUM  = 9'b000000100,
        S_CA   = 9'b000001000,
        S_CB   = 9'b000010000,
        S_CC   = 9'b000100000,
        S_CW   = 9'b001000000,
        S_ER   = 9'b010000000,
        S_EL   = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            layer_reg, layer_next;
    logic [bmst_pkg::COUNT_W-1:0]    bars_reg, bars_next;
    logic [bmst_pkg::IDX_W-1:0]      lt_reg, lt_next;
    logic [bmst_pkg::IDX_W-1:0]      pt_reg, pt_next;
    logic                            fin_reg, fin_next;
    logic [bmst_pkg::CELL_W-1:0]     acc_reg, acc_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bmst_pkg::CELL_W-1:0]     out_value_reg;
    logic [bmst_pkg::IDX_W-1:0]      out_row_reg;
    logic [bmst_pkg::IDX_W-1:0]      out_col_reg;
    logic                            out_last_reg;
    logic [bmst_pkg::IDX_W-1:0]      row_limit_reg;
    logic [bmst_pkg::IDX_W-1:0]      col_limit_reg;
    logic [bmst_pkg::SCALE_W-1:0]    scale_reg;

    logic                            in_accept;
    logic                            out_accept;
    logic [bmst_pkg::IDX_W-1:0]      lim_l;
    logic [bmst_pkg::IDX_W-1:0]      lim_p;
    logic                            cell_last;
    logic [bmst_pkg::COUNT_W-1:0]    bars_inc;
    logic [bmst_pkg::COUNT_W:0]      reach;
    logic                            corner;
    logic                            top_copy;
    logic                            left_copy;
    logic                            en_a;
    logic                            en_b;
    logic                            en_c;
    logic [bmst_pkg::IDX_W-1:0]      lt_dec;
    logic [bmst_pkg::IDX_W-1:0]      pt_dec;
    logic [bmst_pkg::ADDR_W-1:0]     addr_a;
    logic [bmst_pkg::ADDR_W-1:0]     addr_b;
    logic [bmst_pkg::ADDR_W-1:0]     addr_c;
    logic [bmst_pkg::ADDR_W-1:0]     addr_cur;

    logic                            prep_load;
    logic                            pad_load;
    logic [bmst_pkg::BAR_W-1:0]      prep_birth;
    logic [bmst_pkg::BAR_W-1:0]      prep_death;
    logic [bmst_pkg::BAR_W-1:0]      bar_length;
    logic [bmst_pkg::SL_W-1:0]       short_length;

    bmst_pkg::store_req_t            store_req;
    logic [bmst_pkg::CELL_W-1:0]     store_rd_data;
    bmst_pkg::alu_ctrl_t             alu_ctrl;
    logic [bmst_pkg::CELL_W-1:0]     alu_addend;
    logic [bmst_pkg::CELL_W-1:0]     alu_result;

    // True while fewer bars than L+P have been taken in.
    function automatic logic needs_pad(input logic [bmst_pkg::COUNT_W-1:0] n,
                                       input logic [bmst_pkg::IDX_W-1:0] l,
                                       input logic [bmst_pkg::IDX_W-1:0] p);
        logic [bmst_pkg::COUNT_W:0] lp;
        lp = (bmst_pkg::COUNT_W+1)'(l) + (bmst_pkg::COUNT_W+1)'(p);
        return (bmst_pkg::COUNT_W+1)'(n) < lp;
    endfunction

    // Handshakes.
    assign in_accept    = bar_in.valid && bar_in.ready;
    assign out_accept   = cell_out.valid && cell_out.ready;
    assign bar_in.ready = (state_reg == S_IDLE);

    assign cell_out.valid        = out_valid_reg;
    assign cell_out.cell_value   = out_value_reg;
    assign cell_out.row_index    = out_row_reg;
    assign cell_out.column_index = out_col_reg;
    assign cell_out.last         = out_last_reg;

    // Effective limits, clamped to the table size.
    assign lim_l = (row_limit_reg > bmst_pkg::ROW_TOP) ? bmst_pkg::ROW_TOP : row_limit_reg;
    assign lim_p = (col_limit_reg > bmst_pkg::COL_TOP) ? bmst_pkg::COL_TOP : col_limit_reg;

    assign cell_last = (lt_reg == lim_l) && (pt_reg == lim_p);
    assign bars_inc  = (bars_reg == bmst_pkg::COUNT_MAX) ? bars_reg
                                                         : bars_reg + bmst_pkg::COUNT_W'(1);

    // Cell classification: the corner, and first-row or first-column cells
    // beyond the reach of the bars seen so far, which copy their neighbour.
    assign reach     = (bmst_pkg::COUNT_W+1)'(bars_reg) + (bmst_pkg::COUNT_W+1)'(1);
    assign corner    = (lt_reg == '0) && (pt_reg == '0);
    assign top_copy  = (lt_reg == '0) && (pt_reg != '0)
                       && ((bmst_pkg::COUNT_W+1)'(pt_reg) > reach);
    assign left_copy = (pt_reg == '0) && (lt_reg != '0)
                       && ((bmst_pkg::COUNT_W+1)'(lt_reg) > reach);
    assign en_a      = !corner;
    assign en_b      = (lt_reg != '0) && !left_copy;
    assign en_c      = (pt_reg != '0) && !top_copy;

    // Table addresses for the three operands and the cell itself.
    assign lt_dec   = lt_reg - bmst_pkg::IDX_W'(1);
    assign pt_dec   = pt_reg - bmst_pkg::IDX_W'(1);
    assign addr_cur = {layer_reg, lt_reg, pt_reg};
    assign addr_b   = {~layer_reg, lt_dec, pt_reg};
    assign addr_c   = {~layer_reg, lt_reg, pt_dec};

    always_comb
    begin
        if (top_copy)
        begin
            addr_a = {layer_reg, lt_reg, pt_dec};
        end
        else if (left_copy)
        begin
            addr_a = {layer_reg, lt_dec, pt_reg};
        end
        else
        begin
            addr_a = {~layer_reg, lt_reg, pt_reg};
        end
    end

    // Bar front end: a padding bar is loaded as a zero bar.
    assign prep_birth = pad_load ? '0 : bar_in.birth;
    assign prep_death = pad_load ? '0 : bar_in.death;

    bmst_bar_prep u_prep (
        .clk          (clk),
        .load         (prep_load),
        .birth        (prep_birth),
        .death        (prep_death),
        .scale        (scale_reg),
        .bar_length   (bar_length),
        .short_length (short_length)
    );

    bmst_cell_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .wr_data (alu_result),
        .rd_data (store_rd_data)
    );

    // Shared unit: the phase selects the base and the addend.
    always_comb
    begin
        alu_ctrl.base_zero = (state_reg == S_CB);
        alu_ctrl.enable    = en_c;
        alu_addend         = bmst_pkg::CELL_W'(short_length);
        if (state_reg == S_CB)
        begin
            alu_ctrl.enable = en_a;
            alu_addend      = '0;
        end
        else if (state_reg == S_CC)
        begin
            alu_ctrl.enable = en_b;
            alu_addend      = bmst_pkg::CELL_W'(bar_length);
        end
    end

    bmst_max_plus u_alu (
        .ctrl    (alu_ctrl),
        .base    (acc_reg),
        .operand (store_rd_data),
        .addend  (alu_addend),
        .result  (alu_result)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        layer_next     = layer_reg;
        bars_next      = bars_reg;
        lt_next        = lt_reg;
        pt_next        = pt_reg;
        fin_next       = fin_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        prep_load      = 1'b0;
        pad_load       = 1'b0;
        store_req      = '0;

        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    lt_next = '0;
                    pt_next = '0;
                    if (bar_in.opcode == bmst_pkg::OP_BAR)
                    begin
                        prep_load  = 1'b1;
                        layer_next = ~layer_reg;
                        fin_next   = 1'b0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        fin_next = 1'b1;
                        if (needs_pad(bars_reg, lim_l, lim_p))
                        begin
                            prep_load  = 1'b1;
                            pad_load   = 1'b1;
                            layer_next = ~layer_reg;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = S_ER;
                        end
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_CA;
            end
            S_CA:
            begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = addr_a;
                state_next        = S_CB;
            end
            S_CB:
            begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = addr_b;
                acc_next          = alu_result;
                state_next        = S_CC;
            end
            S_CC:
            begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = addr_c;
                acc_next          = alu_result;
                state_next        = S_CW;
            end
            S_CW:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = addr_cur;
                if (cell_last)
                begin
                    bars_next = bars_inc;
                    lt_next   = '0;
                    pt_next   = '0;
                    if (!fin_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (needs_pad(bars_inc, lim_l, lim_p))
                    begin
                        prep_load  = 1'b1;
                        pad_load   = 1'b1;
                        layer_next = ~layer_reg;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_ER;
                    end
                end
                else
                begin
                    if (pt_reg == lim_p)
                    begin
                        pt_next = '0;
                        lt_next = lt_reg + bmst_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        pt_next = pt_reg + bmst_pkg::IDX_W'(1);
                    end
                    state_next = S_CA;
                end
            end
            S_ER:
            begin
                // Read the next cell only once the output register is free.
                if (!out_valid_reg || out_accept)
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = addr_cur;
                    state_next        = S_EL;
                end
            end
            S_EL:
            begin
                out_valid_next = 1'b1;
                if (cell_last)
                begin
                    store_req.clear = 1'b1;
                    layer_next      = 1'b1;
                    bars_next       = '0;
                    fin_next        = 1'b0;
                    lt_next         = '0;
                    pt_next         = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    if (pt_reg == lim_p)
                    begin
                        pt_next = '0;
                        lt_next = lt_reg + bmst_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        pt_next = pt_reg + bmst_pkg::IDX_W'(1);
                    end
                    state_next = S_ER;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            layer_reg     <= 1'b1;
            bars_reg      <= '0;
            lt_reg        <= '0;
            pt_reg        <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            layer_reg     <= layer_next;
            bars_reg      <= bars_next;
            lt_reg        <= lt_next;
            pt_reg        <= pt_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Running maximum and output item payload.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == S_EL)
        begin
            out_value_reg <= store_rd_data;
            out_row_reg   <= lt_reg;
            out_col_reg   <= pt_reg;
            out_last_reg  <= cell_last;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= bmst_pkg::IDX_W'(1);
            col_limit_reg <= bmst_pkg::IDX_W'(1);
            scale_reg     <= bmst_pkg::SCALE_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmst_pkg::CFG_ROW_LIMIT:
                begin
                    row_limit_reg <= cfg_data[bmst_pkg::IDX_W-1:0];
                end
                bmst_pkg::CFG_COLUMN_LIMIT:
                begin
                    col_limit_reg <= cfg_data[bmst_pkg::IDX_W-1:0];
                end
                bmst_pkg::CFG_LENGTH_SCALE:
                begin
                    scale_reg <= cfg_data;
                end
                default:
                begin
                    row_limit_reg <= row_limit_reg;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // Emission starts only after the table has been padded to L+P bars.
    a_pad_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ER) |-> !needs_pad(bars_reg, lim_l, lim_p))
        else $error("emission started before padding finished");

    // Cell walks stay within the current limits.
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CA) |-> (lt_reg <= lim_l) && (pt_reg <= lim_p))
        else $error("cell index beyond the table limits");

    // A result becomes valid only from the emission load step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EL))
        else $error("result raised outside emission");

    // After the final cell the bar count and layer are back at reset.
    a_table_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EL) && cell_last |=> (bars_reg == '0) && layer_reg)
        else $error("table state not cleared after the final cell");
`endif

endmodule

/* tb/barcode_max_selection_table_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// barcode_max_selection_table_core_test: regression for the bar selection table
// Feeds persistence bars and finish requests through the item channel, keeps
// its own max-plus table in step with every accepted item, and checks each
// emitted cell against the expected value, position and end marker. Register
// writes happen only with the block idle, covering extreme and random limits,
// mid-table limit changes, an unused register index, and long bar runs.
// ---------------------------------------------------------------------------
module barcode_max_selection_table_core_test;

    // Pause longer than a bar pass over the largest table takes.
    localparam int IDLE_PAUSE  = 300;
    localparam int STALL_LIMIT = 40000;

    localparam logic [bmst_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [bmst_pkg::BAR_W-1:0]     BAR_MAX    = '1;

    typedef struct packed {
        logic [bmst_pkg::CELL_W-1:0] cell_value;
        logic [bmst_pkg::IDX_W-1:0]  row_index;
        logic [bmst_pkg::IDX_W-1:0]  column_index;
        logic                        last;
    } cell_rec_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [bmst_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bmst_pkg::CFG_DATA_W-1:0] cfg_data;

    bmst_in_if  bar_if ();
    bmst_out_if cell_if ();

    barcode_max_selection_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bar_in    (bar_if),
        .cell_out  (cell_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the table and its registers.
    logic [bmst_pkg::CELL_W-1:0]  score_grid [2][bmst_pkg::MAX_ROWS][bmst_pkg::MAX_COLUMNS];
    logic                         layer_sel;
    logic [bmst_pkg::COUNT_W-1:0] bar_count;
    logic [bmst_pkg::IDX_W-1:0]   rows_cfg;
    logic [bmst_pkg::IDX_W-1:0]   cols_cfg;
    logic [bmst_pkg::SCALE_W-1:0] scale_cfg;

    cell_rec_t expected_cells [$];

    int mismatches    = 0;
    int cells_checked = 0;
    int bars_sent     = 0;
    int finishes_sent = 0;
    int items_sent    = 0;
    int cfg_writes    = 0;
    int quiet_cycles  = 0;
    bit steady        = 1'b0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: stalls with a chance of about seven in a hundred unless steady.
    initial
    begin
        cell_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cell_if.ready = steady || ($urandom_range(99) >= 7);
        end
    end

    // Saturating sum of two cell values.
    function automatic logic [bmst_pkg::CELL_W-1:0] cap_add(
        input logic [bmst_pkg::CELL_W-1:0] a,
        input logic [bmst_pkg::CELL_W-1:0] b);
        logic [bmst_pkg::CELL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, bmst_pkg::CELL_MAX}) ? bmst_pkg::CELL_MAX
                                                : s[bmst_pkg::CELL_W-1:0];
    endfunction

    function automatic int top_row();
        return (int'(rows_cfg) < bmst_pkg::MAX_ROWS - 1) ? int'(rows_cfg)
                                                         : bmst_pkg::MAX_ROWS - 1;
    endfunction

    function automatic int top_col();
        return (int'(cols_cfg) < bmst_pkg::MAX_COLUMNS - 1) ? int'(cols_cfg)
                                                            : bmst_pkg::MAX_COLUMNS - 1;
    endfunction

    function automatic void clear_grid();
        foreach (score_grid[l, r, c])
            score_grid[l][r][c] = '0;
        layer_sel = 1'b1;
        bar_count = '0;
    endfunction

    // Folds one bar into the opposite layer of the table.
    function automatic void fold_bar(input logic [bmst_pkg::CELL_W-1:0] sh,
                                     input logic [bmst_pkg::CELL_W-1:0] len);
        int                          lr;
        int                          pc;
        int                          n;
        int                          cur;
        int                          prv;
        logic [bmst_pkg::CELL_W-1:0] best;
        logic [bmst_pkg::CELL_W-1:0] step;
        logic [bmst_pkg::CELL_W-1:0] diag;
        lr        = top_row();
        pc        = top_col();
        n         = int'(bar_count);
        layer_sel = ~layer_sel;
        cur       = int'(layer_sel);
        prv       = cur ^ 1;
        diag      = cap_add(sh, len);
        for (int r = 0; r <= lr; r++)
        begin
            for (int c = 0; c <= pc; c++)
            begin
                if (r == 0 && c == 0)
                    best = '0;
                else if (r == 0)
                begin
                    // Columns beyond reach of the bars so far copy their neighbour.
                    if (c > n + 1)
                        best = score_grid[cur][0][c-1];
                    else
                    begin
                        best = score_grid[prv][0][c];
                        step = cap_add(score_grid[prv][0][c-1], diag);
                        if (step > best)
                            best = step;
                    end
                end
                else if (c == 0)
                begin
                    if (r > n + 1)
                        best = score_grid[cur][r-1][0];
                    else
                    begin
                        best = score_grid[prv][r][0];
                        step = cap_add(score_grid[prv][r-1][0], len);
                        if (step > best)
                            best = step;
                    end
                end
                else
                begin
                    best = score_grid[prv][r][c];
                    step = cap_add(score_grid[prv][r-1][c], len);
                    if (step > best)
                        best = step;
                    step = cap_add(score_grid[prv][r][c-1], diag);
                    if (step > best)
                        best = step;
                end
                score_grid[cur][r][c] = best;
            end
        end
        if (bar_count != bmst_pkg::COUNT_MAX)
            bar_count++;
    endfunction

    // Works out the cells that one accepted item produces.
    function automatic void predict_item(input logic op,
                                         input logic [bmst_pkg::BAR_W-1:0] birth,
                                         input logic [bmst_pkg::BAR_W-1:0] death);
        logic [bmst_pkg::BAR_W-1:0]  b;
        logic [bmst_pkg::BAR_W-1:0]  d;
        logic [bmst_pkg::CELL_W-1:0] len;
        logic [bmst_pkg::CELL_W-1:0] sh;
        logic [bmst_pkg::PROD_W-1:0] prod;
        int                          lr;
        int                          pc;
        int                          cur;
        cell_rec_t                   rec;
        if (op == bmst_pkg::OP_BAR)
        begin
            b    = birth & bmst_pkg::VALUE_MASK;
            d    = death & bmst_pkg::VALUE_MASK;
            len  = (d > b) ? bmst_pkg::CELL_W'(d - b) : '0;
            prod = bmst_pkg::PROD_W'(scale_cfg)
                   * bmst_pkg::PROD_W'(len[bmst_pkg::BAR_W-1:0]);
            sh   = prod[bmst_pkg::PROD_W-1:8];
            if (sh > bmst_pkg::CELL_W'(b))
                sh = bmst_pkg::CELL_W'(b);
            fold_bar(sh, len);
        end
        else
        begin
            lr = top_row();
            pc = top_col();
            // Pad with empty bars until every cell is reachable.
            while (int'(bar_count) < lr + pc)
                fold_bar('0, '0);
            cur = int'(layer_sel);
            for (int r = 0; r <= lr; r++)
            begin
                for (int c = 0; c <= pc; c++)
                begin
                    rec.cell_value   = score_grid[cur][r][c];
                    rec.row_index    = bmst_pkg::IDX_W'(r);
                    rec.column_index = bmst_pkg::IDX_W'(c);
                    rec.last         = (r == lr && c == pc);
                    expected_cells   = {expected_cells, rec};
                end
            end
            clear_grid();
        end
    endfunction

    // Sends one item; entered and left at a falling edge.
    task automatic send_item(input logic op, input logic [bmst_pkg::BAR_W-1:0] birth,
                             input logic [bmst_pkg::BAR_W-1:0] death);
        while (!steady && $urandom_range(99) < 7)
            @(negedge clk);
        bar_if.opcode = op;
        bar_if.birth  = birth;
        bar_if.death  = death;
        bar_if.valid  = 1'b1;
        do
            @(posedge clk);
        while (!bar_if.ready);
        predict_item(op, birth, death);
        items_sent++;
        if (op == bmst_pkg::OP_BAR)
            bars_sent++;
        else
            finishes_sent++;
        @(negedge clk);
        bar_if.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [bmst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bmst_pkg::CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            bmst_pkg::CFG_ROW_LIMIT:    rows_cfg  = value[bmst_pkg::IDX_W-1:0];
            bmst_pkg::CFG_COLUMN_LIMIT: cols_cfg  = value[bmst_pkg::IDX_W-1:0];
            bmst_pkg::CFG_LENGTH_SCALE: scale_cfg = value;
            default:                    ;
        endcase
        cfg_writes++;
    endtask

    // Waits for every pending cell, then for the block to finish a bar pass.
    task automatic settle();
        while (expected_cells.size() != 0)
            @(negedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
    endtask

    task automatic set_shape(input int rows, input int cols, input int scale);
        settle();
        write_reg(bmst_pkg::CFG_ROW_LIMIT, bmst_pkg::CFG_DATA_W'(rows));
        write_reg(bmst_pkg::CFG_COLUMN_LIMIT, bmst_pkg::CFG_DATA_W'(cols));
        write_reg(bmst_pkg::CFG_LENGTH_SCALE, bmst_pkg::CFG_DATA_W'(scale));
    endtask

    // Random bar with a bias towards small values, reversed bars and extremes.
    task automatic pick_bar(output logic [bmst_pkg::BAR_W-1:0] birth,
                            output logic [bmst_pkg::BAR_W-1:0] death);
        int kind;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            birth = bmst_pkg::BAR_W'($urandom_range(32'h0010_0000));
            death = birth + bmst_pkg::BAR_W'($urandom_range(32'h0004_0000));
        end
        else if (kind < 60)
        begin
            birth = $urandom;
            death = $urandom;
        end
        else if (kind < 75)
        begin
            death = bmst_pkg::BAR_W'($urandom_range(32'h0100_0000));
            birth = death + bmst_pkg::BAR_W'($urandom_range(32'h0010_0000));
        end
        else if (kind < 85)
        begin
            birth = $urandom;
            death = birth;
        end
        else
        begin
            birth = $urandom_range(1) ? BAR_MAX : bmst_pkg::BAR_W'($urandom_range(1));
            death = $urandom_range(1) ? BAR_MAX : bmst_pkg::BAR_W'($urandom_range(1));
        end
    endtask

    // Checks each accepted cell against the oldest expected one.
    always @(posedge clk)
    begin : check_cells
        cell_rec_t got;
        cell_rec_t want;
        if (rst_n && cell_if.valid && cell_if.ready)
        begin
            got.cell_value   = cell_if.cell_value;
            got.row_index    = cell_if.row_index;
            got.column_index = cell_if.column_index;
            got.last         = cell_if.last;
            cells_checked++;
            if (expected_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected cell (%0d,%0d) value %0h last %0b", $realtime,
                             got.row_index, got.column_index, got.cell_value, got.last);
            end
            else
            begin
                want = expected_cells.pop_front();
                if (got.cell_value !== want.cell_value || got.row_index !== want.row_index
                    || got.column_index !== want.column_index || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected (%0d,%0d) %0h/%0b, got (%0d,%0d) %0h/%0b",
                                 $realtime, want.row_index, want.column_index, want.cell_value,
                                 want.last, got.row_index, got.column_index, got.cell_value,
                                 got.last);
                end
            end
        end
    end

    // Ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((bar_if.valid && bar_if.ready) || (cell_if.valid && cell_if.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d cells still pending", $realtime,
                     quiet_cycles, expected_cells.size());
            $display("barcode_max_selection_table_core regression: fail");
            $finish;
        end
    end

    // Reset register values with two small bars.
    task automatic test_reset_settings();
        send_item(bmst_pkg::OP_BAR, 32'h0001_0000, 32'h0003_8000);
        send_item(bmst_pkg::OP_BAR, 32'h0002_0000, 32'h0002_4000);
        send_item(bmst_pkg::OP_FINISH, '0, '0);
    endtask

    // A single-cell table with no bars emits just a zero.
    task automatic test_empty_table();
        set_shape(0, 0, 256);
        send_item(bmst_pkg::OP_FINISH, '0, '0);
    endtask

    // Largest table and scale against the extremes of birth and death.
    task automatic test_field_extremes();
        set_shape(7, 7, 65535);
        send_item(bmst_pkg::OP_BAR, '0, BAR_MAX);
        send_item(bmst_pkg::OP_BAR, BAR_MAX, '0);
        send_item(bmst_pkg::OP_BAR, BAR_MAX, BAR_MAX);
        send_item(bmst_pkg::OP_BAR, '0, '0);
        send_item(bmst_pkg::OP_BAR, 32'h0000_0001, BAR_MAX);
        send_item(bmst_pkg::OP_BAR, 32'h8000_0000, BAR_MAX);
        send_item(bmst_pkg::OP_FINISH, '0, '0);
    endtask

    // A zero scale makes every short term vanish.
    task automatic test_zero_scale();
        set_shape(3, 2, 0);
        send_item(bmst_pkg::OP_BAR, 32'h0004_0000, 32'h0009_0000);
        send_item(bmst_pkg::OP_BAR, 32'h0000_8000, 32'h0001_8000);
        send_item(bmst_pkg::OP_FINISH, '0, '0);
    endtask

    // Limits widened part way through a table apply from the next bar on.
    task automatic test_limits_between_bars();
        set_shape(2, 1, 384);
        send_item(bmst_pkg::OP_BAR, 32'h0001_0000, 32'h0005_0000);
        send_item(bmst_pkg::OP_BAR, 32'h0003_0000, 32'h0004_0000);
        settle();
        write_reg(bmst_pkg::CFG_ROW_LIMIT, 16'd5);
        write_reg(bmst_pkg::CFG_COLUMN_LIMIT, 16'd6);
        send_item(bmst_pkg::OP_BAR, 32'h0002_0000, 32'h0007_0000);
        send_item(bmst_pkg::OP_BAR, 32'h0000_4000, 32'h0000_2000);
        send_item(bmst_pkg::OP_FINISH, '0, '0);
    endtask

    // A write to the unused register index must change nothing.
    task automatic test_unused_register();
        set_shape(1, 2, 256);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_item(bmst_pkg::OP_BAR, 32'h0001_0000, 32'h0002_0000);
        send_item(bmst_pkg::OP_FINISH, '0, '0);
    endtask

    // Random tables: mostly runs of up to L+P+2 bars, some short, some past the counter limit.
    task automatic test_random_tables();
        int                         set_no;
        int                         nbars;
        int                         pick;
        int                         rows;
        int                         cols;
        int                         scale;
        logic [bmst_pkg::BAR_W-1:0] birth;
        logic [bmst_pkg::BAR_W-1:0] death;
        set_no = 0;
        while (items_sent < 440)
        begin
            steady = (set_no >= 20 && set_no < 30);
            if (set_no == 0 || $urandom_range(3) == 0)
            begin
                if ($urandom_range(9) < 3)
                begin
                    rows  = $urandom_range(1) ? 7 : 0;
                    cols  = $urandom_range(1) ? 7 : 0;
                    scale = $urandom_range(1) ? 65535 : 0;
                end
                else
                begin
                    rows  = $urandom_range(7);
                    cols  = $urandom_range(7);
                    scale = $urandom_range(65535);
                end
                set_shape(rows, cols, scale);
            end
            pick = $urandom_range(99);
            if (pick < 85)
                nbars = $urandom_range(top_row() + top_col() + 2);
            else if (pick < 95)
                nbars = $urandom_range(3);
            else
                nbars = $urandom_range(36, 30);
            for (int i = 0; i < nbars; i++)
            begin
                // Occasionally reshape the table between two bars.
                if (i == nbars / 2 && $urandom_range(9) == 0)
                begin
                    settle();
                    write_reg(bmst_pkg::CFG_ROW_LIMIT,
                              bmst_pkg::CFG_DATA_W'($urandom_range(7)));
                    write_reg(bmst_pkg::CFG_COLUMN_LIMIT,
                              bmst_pkg::CFG_DATA_W'($urandom_range(7)));
                end
                pick_bar(birth, death);
                send_item(bmst_pkg::OP_BAR, birth, death);
            end
            send_item(bmst_pkg::OP_FINISH, $urandom, $urandom);
            set_no++;
        end
        steady = 1'b0;
    endtask

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        bar_if.valid  = 1'b0;
        bar_if.opcode = bmst_pkg::OP_BAR;
        bar_if.birth  = '0;
        bar_if.death  = '0;
        rows_cfg      = 3'd1;
        cols_cfg      = 3'd1;
        scale_cfg     = 16'd256;
        clear_grid();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_settings();
        test_empty_table();
        test_field_extremes();
        test_zero_scale();
        test_limits_between_bars();
        test_unused_register();
        test_random_tables();
        settle();

        $display("Run covered %0d bars and %0d finished tables over %0d register writes.",
                 bars_sent, finishes_sent, cfg_writes);
        $display("%0d cells checked, %0d mismatches, %0d cells never emitted.",
                 cells_checked, mismatches, expected_cells.size());
        if (mismatches == 0 && expected_cells.size() == 0)
            $display("barcode_max_selection_table_core regression: pass");
        else
            $display("barcode_max_selection_table_core regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bmst_pkg.sv
rtl/bmst_in_if.sv
rtl/bmst_out_if.sv
rtl/bmst_cell_store.sv
rtl/bmst_bar_prep.sv
rtl/bmst_max_plus.sv
rtl/barcode_max_selection_table_core.sv
tb/barcode_max_selection_table_core_test.sv
